>>> design/ctw_pkg.sv
// Shared constants and types for the cycle timer and watchdog peripheral.
`default_nettype none

package ctw_pkg;

  // Default watchdog counter width
  localparam int WATCHDOG_BITS_DEF = 24;

  // Timer width and number of timers (index 0 = IRQ, 1 = NMI)
  localparam int TMR_BITS = 16;
  localparam int TMR_COUNT = 2;
  localparam int TMR_IRQ = 0;
  localparam int TMR_NMI = 1;

  // I/O page decode: timer block at 0x10-0x17, watchdog at 0x20-0x23
  localparam logic [4:0] TMR_PAGE = 5'h02;   // reg_offset[7:3]
  localparam logic [5:0] WD_PAGE  = 6'h08;   // reg_offset[7:2]

  // Watchdog register select codes (reg_offset[1:0])
  localparam logic [1:0] WD_SEL_STOP  = 2'd0;
  localparam logic [1:0] WD_SEL_BYTE0 = 2'd1;
  localparam logic [1:0] WD_SEL_BYTE1 = 2'd2;
  localparam logic [1:0] WD_SEL_BYTE2 = 2'd3;

  // Status byte values
  localparam logic [7:0] STATUS_SET   = 8'h80;
  localparam logic [7:0] STATUS_CLEAR = 8'h00;

  // Stream payload widths (whole bytes)
  localparam int IN_DATA_BITS  = 24;
  localparam int OUT_DATA_BITS = 16;

  // One bus cycle, unpacked from the input stream
  typedef struct packed {
    logic       cpu_reset_active;
    logic [7:0] write_data;
    logic [7:0] reg_offset;
    logic       is_read;
    logic       io_select;
  } bus_cycle_t;

  // One result, as packed into the output stream
  typedef struct packed {
    logic       watchdog_trap;
    logic       nmi_line_low;
    logic       irq_line_low;
    logic       read_driven;
    logic [7:0] read_data;
  } bus_result_t;

endpackage

`default_nettype wire

>>> design/cycle_timer_watchdog_peripheral_top.sv
// Top level of the cycle timer and watchdog peripheral: two timers, watchdog, stream ports.
//
//  Channel | Dir | Bus            | Contents
//  --------+-----+----------------+---------------------------------------------
//  s_*     | in  | tvalid/tready  | one CPU bus cycle (also one timer tick)
//  m_*     | out | tvalid/tready  | read answer, line levels and watchdog trap
//
//  One transaction per clock while m_tready keeps up: every accepted bus cycle is
//  ticked, decoded and applied to the timer state in its accept cycle; the result is
//  captured in the output register and shows on m_* in the next cycle.
//  s_tready is high while the output register is empty or being drained, so a
//  stalled m_tready only holds the input once one result is waiting.
//  rst clears all timer, watchdog and handshake state.
`default_nettype none

module cycle_timer_watchdog_peripheral_top
  import ctw_pkg::*;
#(
  parameter int WATCHDOG_BITS = WATCHDOG_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // bits from 0: io_select, is_read, reg_offset[7:0], write_data[7:0],
  // cpu_reset_active, zero fill
  input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // bits from 0: read_data[7:0], read_driven, irq_line_low, nmi_line_low,
  // watchdog_trap, zero fill
  output logic [OUT_DATA_BITS-1:0]      m_tdata,
  output logic                          m_tvalid,
  input  wire logic                     m_tready
);

  bus_cycle_t  cyc;
  bus_result_t res;
  logic        s_fire;

  // Result fields, each from its own block
  logic [7:0]  rd_data;
  logic        rd_driven;
  logic        wd_trap;

  // Timer state (index TMR_IRQ / TMR_NMI)
  logic [TMR_BITS-1:0] tmr_reload         [TMR_COUNT];
  logic [TMR_BITS-1:0] tmr_remaining      [TMR_COUNT];
  logic [TMR_COUNT-1:0] tmr_armed;
  logic [TMR_COUNT-1:0] tmr_flag;
  logic [TMR_COUNT-1:0] tmr_line;
  logic [TMR_BITS-1:0] tmr_reload_next    [TMR_COUNT];
  logic [TMR_BITS-1:0] tmr_remaining_next [TMR_COUNT];
  logic [TMR_COUNT-1:0] tmr_armed_next;
  logic [TMR_COUNT-1:0] tmr_flag_next;
  logic [TMR_COUNT-1:0] tmr_line_next;

  // Watchdog state
  logic [WATCHDOG_BITS-1:0] wd_total;
  logic [WATCHDOG_BITS-1:0] wd_remaining;
  logic                     wd_armed;
  logic [WATCHDOG_BITS-1:0] wd_total_next;
  logic [WATCHDOG_BITS-1:0] wd_remaining_next;
  logic                     wd_armed_next;

  // Decode
  logic tmr_hit;
  logic wd_hit;
  logic bus_read;
  logic bus_write;

  assign cyc       = bus_cycle_t'(s_tdata[$bits(bus_cycle_t)-1:0]);
  assign s_tready  = !m_tvalid || m_tready;
  assign s_fire    = s_tvalid && s_tready;
  assign tmr_hit   = (cyc.reg_offset[7:3] == TMR_PAGE);
  assign wd_hit    = (cyc.reg_offset[7:2] == WD_PAGE);
  assign bus_read  = cyc.io_select && !cyc.cpu_reset_active && cyc.is_read;
  assign bus_write = cyc.io_select && !cyc.cpu_reset_active && !cyc.is_read;

  // Timers: tick, then CPU reset, then bus access
  always_comb begin
    logic [TMR_BITS-1:0] rl;
    logic [TMR_BITS-1:0] rm;
    logic                ar;
    logic                fl;
    logic                ln;
    logic                sel;
    rd_data   = STATUS_CLEAR;
    rd_driven = 1'b0;
    for (int i = 0; i < TMR_COUNT; i++) begin
      rl  = tmr_reload[i];
      rm  = tmr_remaining[i];
      ar  = tmr_armed[i];
      fl  = tmr_flag[i];
      ln  = tmr_line[i];
      sel = tmr_hit && (cyc.reg_offset[2] == (i == TMR_NMI));
      // tick
      if (ar) begin
        if (rm <= TMR_BITS'(1)) begin
          ln = 1'b1;
          fl = 1'b1;
          if (rl != '0) begin
            rm = rl;
          end else begin
            ar = 1'b0;
          end
        end else begin
          rm = rm - TMR_BITS'(1);
        end
      end
      // CPU reset keeps line levels
      if (cyc.cpu_reset_active) begin
        rl = '0;
        rm = '0;
        ar = 1'b0;
        fl = 1'b0;
      end else if (bus_write && sel) begin
        if (cyc.reg_offset[0]) begin
          rl = rl | {cyc.write_data, 8'h00};
          rm = rl;
          ar = 1'b1;
          if (cyc.reg_offset[1]) begin
            rl = '0;
          end
        end else begin
          ar = 1'b0;
          rl = {8'h00, cyc.write_data};
        end
      end else if (bus_read && sel) begin
        rd_data   = fl ? STATUS_SET : STATUS_CLEAR;
        rd_driven = 1'b1;
        fl = 1'b0;
        ln = 1'b0;
      end
      tmr_reload_next[i]    = rl;
      tmr_remaining_next[i] = rm;
      tmr_armed_next[i]     = ar;
      tmr_flag_next[i]      = fl;
      tmr_line_next[i]      = ln;
    end
    // watchdog status read
    if (bus_read && wd_hit) begin
      rd_data   = (wd_total != '0) ? STATUS_SET : STATUS_CLEAR;
      rd_driven = 1'b1;
    end
  end

  // Watchdog: tick, then CPU reset, then bus write
  always_comb begin
    logic [31:0] tot_ext;
    wd_total_next     = wd_total;
    wd_remaining_next = wd_remaining;
    wd_armed_next     = wd_armed;
    wd_trap           = 1'b0;
    tot_ext           = 32'(wd_total);
    if (wd_armed) begin
      if (wd_remaining <= WATCHDOG_BITS'(1)) begin
        wd_trap       = 1'b1;
        wd_armed_next = 1'b0;
      end else begin
        wd_remaining_next = wd_remaining - WATCHDOG_BITS'(1);
      end
    end
    if (cyc.cpu_reset_active) begin
      wd_total_next     = '0;
      wd_remaining_next = '0;
      wd_armed_next     = 1'b0;
    end else if (bus_write && wd_hit) begin
      if (cyc.reg_offset[1:0] == WD_SEL_STOP) begin
        wd_armed_next = 1'b0;
        wd_total_next = '0;
      end else if (wd_armed_next) begin
        wd_remaining_next = wd_total;
      end else begin
        case (cyc.reg_offset[1:0])
          WD_SEL_BYTE0: tot_ext[7:0]   = cyc.write_data;
          WD_SEL_BYTE1: tot_ext[15:8]  = cyc.write_data;
          WD_SEL_BYTE2: tot_ext[23:16] = cyc.write_data;
          default:      tot_ext        = 32'(wd_total);
        endcase
        wd_total_next = tot_ext[WATCHDOG_BITS-1:0];
        if (cyc.reg_offset[1:0] == WD_SEL_BYTE2) begin
          wd_armed_next     = 1'b1;
          wd_remaining_next = tot_ext[WATCHDOG_BITS-1:0];
        end
      end
    end
  end

  // Result of this transaction, packed from the top field down
  assign res = bus_result_t'({wd_trap, tmr_line_next[TMR_NMI], tmr_line_next[TMR_IRQ],
                              rd_driven, rd_data});

  // State update on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TMR_COUNT; i++) begin
        tmr_reload[i]    <= '0;
        tmr_remaining[i] <= '0;
      end
      tmr_armed    <= '0;
      tmr_flag     <= '0;
      tmr_line     <= '0;
      wd_total     <= '0;
      wd_remaining <= '0;
      wd_armed     <= 1'b0;
    end else if (s_fire) begin
      for (int i = 0; i < TMR_COUNT; i++) begin
        tmr_reload[i]    <= tmr_reload_next[i];
        tmr_remaining[i] <= tmr_remaining_next[i];
      end
      tmr_armed    <= tmr_armed_next;
      tmr_flag     <= tmr_flag_next;
      tmr_line     <= tmr_line_next;
      wd_total     <= wd_total_next;
      wd_remaining <= wd_remaining_next;
      wd_armed     <= wd_armed_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_tdata <= OUT_DATA_BITS'(res);
    end
  end

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking stream testbench for the cycle timer and watchdog peripheral.
module testbench;
  import ctw_pkg::*;

  localparam int CYCLE_BITS  = $bits(bus_cycle_t);
  localparam int RESULT_BITS = $bits(bus_result_t);
  localparam logic [31:0] WD_MASK = 32'((64'd1 << WATCHDOG_BITS_DEF) - 64'd1);

  // Register offsets in the I/O page
  localparam logic [7:0] OFF_IRQ_LO  = 8'h10;
  localparam logic [7:0] OFF_NMI_LO  = 8'h14;
  localparam logic [7:0] OFF_WD_STOP = 8'h20;
  localparam logic [7:0] OFF_WD_B0   = 8'h21;
  localparam logic [7:0] OFF_WD_B1   = 8'h22;
  localparam logic [7:0] OFF_WD_B2   = 8'h23;
  localparam logic [7:0] OFF_UNMAPPED = 8'hFF;
  // Timer offset bits: high byte, one-shot
  localparam logic [7:0] TMR_HI_BIT      = 8'h01;
  localparam logic [7:0] TMR_ONESHOT_BIT = 8'h02;

  // Tracks timer and watchdog state, predicts each result and checks it
  class bus_scoreboard;
    logic [TMR_BITS-1:0] tmr_reload [TMR_COUNT];
    logic [TMR_BITS-1:0] tmr_remain [TMR_COUNT];
    bit tmr_armed [TMR_COUNT];
    bit tmr_flag [TMR_COUNT];
    bit tmr_line [TMR_COUNT];
    logic [31:0] wd_total;
    logic [31:0] wd_remain;
    bit wd_armed;
    bus_result_t expected_q[$];
    int mismatches;
    int checked;
    int traps_seen;
    int status_reads;
    int timer_fires;

    function new();
      for (int i = 0; i < TMR_COUNT; i++) begin
        tmr_reload[i] = '0;
        tmr_remain[i] = '0;
        tmr_armed[i] = 0;
        tmr_flag[i] = 0;
        tmr_line[i] = 0;
      end
      wd_total = '0;
      wd_remain = '0;
      wd_armed = 0;
    endfunction

    function void tick_timer(int i);
      if (!tmr_armed[i]) return;
      if (tmr_remain[i] <= 1) begin
        tmr_line[i] = 1;
        tmr_flag[i] = 1;
        timer_fires++;
        if (tmr_reload[i] != 0) tmr_remain[i] = tmr_reload[i];
        else tmr_armed[i] = 0;
      end else begin
        tmr_remain[i] = tmr_remain[i] - 1'b1;
      end
    endfunction

    function void write_timer(int i, logic [1:0] sel, logic [7:0] data);
      if (sel[0]) begin
        // high byte: OR in and (re)start, one-shot drops the reload afterwards
        tmr_reload[i] = tmr_reload[i] | {data, 8'h00};
        tmr_remain[i] = tmr_reload[i];
        tmr_armed[i] = 1;
        if (sel[1]) tmr_reload[i] = '0;
      end else begin
        tmr_armed[i] = 0;
        tmr_reload[i] = {8'h00, data};
      end
    endfunction

    function void write_watchdog(logic [1:0] sel, logic [7:0] data);
      int sh;
      if (sel == WD_SEL_STOP) begin
        wd_armed = 0;
        wd_total = '0;
      end else if (wd_armed) begin
        wd_remain = wd_total;
      end else begin
        sh = (int'(sel) - 1) * 8;
        wd_total = wd_total & ~(32'hFF << sh);
        wd_total = wd_total | (32'(data) << sh);
        wd_total = wd_total & WD_MASK;
        if (sel == WD_SEL_BYTE2) begin
          wd_armed = 1;
          wd_remain = wd_total;
        end
      end
    endfunction

    // One accepted bus cycle: tick, then reset, then the access
    function void note_cycle(bus_cycle_t c);
      logic [7:0] rdata;
      logic driven;
      logic trap;
      int idx;
      bus_result_t r;
      rdata = STATUS_CLEAR;
      driven = 0;
      trap = 0;
      tick_timer(TMR_IRQ);
      tick_timer(TMR_NMI);
      if (wd_armed) begin
        if (wd_remain <= 1) begin
          trap = 1;
          wd_armed = 0;
        end else begin
          wd_remain = wd_remain - 1;
        end
      end
      idx = c.reg_offset[2] ? TMR_NMI : TMR_IRQ;
      if (c.cpu_reset_active) begin
        // lines keep their level while reset is held
        for (int i = 0; i < TMR_COUNT; i++) begin
          tmr_reload[i] = '0;
          tmr_remain[i] = '0;
          tmr_armed[i] = 0;
          tmr_flag[i] = 0;
        end
        wd_total = '0;
        wd_remain = '0;
        wd_armed = 0;
      end else if (c.io_select) begin
        if (c.is_read) begin
          if (c.reg_offset[7:3] == TMR_PAGE) begin
            rdata = tmr_flag[idx] ? STATUS_SET : STATUS_CLEAR;
            tmr_flag[idx] = 0;
            tmr_line[idx] = 0;
            driven = 1;
          end else if (c.reg_offset[7:2] == WD_PAGE) begin
            rdata = (wd_total != 0) ? STATUS_SET : STATUS_CLEAR;
            driven = 1;
          end
        end else if (c.reg_offset[7:3] == TMR_PAGE) begin
          write_timer(idx, c.reg_offset[1:0], c.write_data);
        end else if (c.reg_offset[7:2] == WD_PAGE) begin
          write_watchdog(c.reg_offset[1:0], c.write_data);
        end
      end
      if (driven) status_reads++;
      r.read_data = rdata;
      r.read_driven = driven;
      r.irq_line_low = tmr_line[TMR_IRQ];
      r.nmi_line_low = tmr_line[TMR_NMI];
      r.watchdog_trap = trap;
      expected_q.push_back(r);
    endfunction

    function void note_mismatch(string field, int want, int got);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, field, want, got);
    endfunction

    function void check_result(bus_result_t got);
      bus_result_t want;
      if (expected_q.size() == 0) begin
        note_mismatch("result with none pending", -1, int'(got));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.watchdog_trap) traps_seen++;
      if (got.read_data !== want.read_data)
        note_mismatch("read_data", want.read_data, got.read_data);
      if (got.read_driven !== want.read_driven)
        note_mismatch("read_driven", want.read_driven, got.read_driven);
      if (got.irq_line_low !== want.irq_line_low)
        note_mismatch("irq_line_low", want.irq_line_low, got.irq_line_low);
      if (got.nmi_line_low !== want.nmi_line_low)
        note_mismatch("nmi_line_low", want.nmi_line_low, got.nmi_line_low);
      if (got.watchdog_trap !== want.watchdog_trap)
        note_mismatch("watchdog_trap", want.watchdog_trap, got.watchdog_trap);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [IN_DATA_BITS-1:0] s_tdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;

  bus_scoreboard sb;
  bit tx_gaps = 0;
  bit rx_stalls = 0;
  bit long_hold_req = 0;
  int items_sent = 0;
  bus_result_t seen_result;

  always #5 clk = ~clk;

  cycle_timer_watchdog_peripheral_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  // Monitor: log accepted bus cycles, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        seen_result = m_tdata[RESULT_BITS-1:0];
        sb.check_result(seen_result);
      end
      if (s_tvalid && s_tready) sb.note_cycle(s_tdata[CYCLE_BITS-1:0]);
    end
  end

  // Result receiver: random stall bursts plus one long hold on request
  initial begin
    wait (!rst);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        m_tready = 1'b0;
        repeat (200) @(negedge clk);
        long_hold_req = 0;
        m_tready = 1'b1;
      end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        m_tready = 1'b1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Bus cycle builders
  function automatic bus_cycle_t bus_write(logic [7:0] off, logic [7:0] data);
    bus_cycle_t c;
    c = '0;
    c.io_select = 1'b1;
    c.reg_offset = off;
    c.write_data = data;
    return c;
  endfunction

  function automatic bus_cycle_t bus_read(logic [7:0] off);
    bus_cycle_t c;
    c = '0;
    c.io_select = 1'b1;
    c.is_read = 1'b1;
    c.reg_offset = off;
    c.write_data = 8'($urandom);
    return c;
  endfunction

  function automatic bus_cycle_t bus_noise(bit in_reset, bit off_page);
    bus_cycle_t c;
    c = CYCLE_BITS'($urandom);
    c.cpu_reset_active = in_reset;
    if (off_page) c.io_select = 1'b0;
    return c;
  endfunction

  // Offer one bus cycle; called and returns at a falling edge
  task automatic send_cycle(input bus_cycle_t c);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_tdata = {{(IN_DATA_BITS - CYCLE_BITS){1'b0}}, c};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // Sender pause until every pending result has come back
  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  // Mostly well-formed timer and watchdog programming, with noise and resets
  task automatic run_random(int target);
    int pick;
    logic [7:0] base;
    logic [7:0] hi;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        base = $urandom_range(0, 1) ? OFF_NMI_LO : OFF_IRQ_LO;
        send_cycle(bus_write(base, 8'($urandom_range(0, 40))));
        hi = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        if ($urandom_range(0, 2) == 0) base = base | TMR_ONESHOT_BIT;
        send_cycle(bus_write(base | TMR_HI_BIT, hi));
      end else if (pick < 55) begin
        if ($urandom_range(0, 3) != 0)
          send_cycle(bus_read(OFF_IRQ_LO + 8'($urandom_range(0, 7))));
        else
          send_cycle(bus_read(OFF_WD_STOP + 8'($urandom_range(0, 3))));
      end else if (pick < 70) begin
        if ($urandom_range(0, 2) == 0) send_cycle(bus_write(OFF_WD_STOP, 8'($urandom)));
        send_cycle(bus_write(OFF_WD_B0, 8'($urandom_range(0, 80))));
        send_cycle(bus_write(OFF_WD_B1,
                             ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00));
        send_cycle(bus_write(OFF_WD_B2,
                             ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00));
      end else if (pick < 76) begin
        send_cycle(bus_write(OFF_WD_STOP + 8'($urandom_range(1, 3)), 8'($urandom)));
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6)) send_cycle(bus_noise(1'b0, 1'b1));
      end else if (pick < 97) begin
        send_cycle(bus_noise(1'b0, 1'b0));
      end else begin
        repeat ($urandom_range(1, 3)) send_cycle(bus_noise(1'b1, 1'b0));
      end
    end
  endtask

  // Main sequence
  initial begin
    sb = new();
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed: idle read, zero count expiring next cycle, periodic NMI
    send_cycle(bus_read(OFF_IRQ_LO));
    send_cycle(bus_write(OFF_IRQ_LO, 8'h00));
    send_cycle(bus_write(OFF_IRQ_LO | TMR_HI_BIT, 8'h00));
    send_cycle(bus_noise(1'b0, 1'b1));
    send_cycle(bus_read(OFF_IRQ_LO | TMR_ONESHOT_BIT));
    send_cycle(bus_write(OFF_NMI_LO, 8'h03));
    send_cycle(bus_write(OFF_NMI_LO | TMR_HI_BIT, 8'h00));
    repeat (3) send_cycle(bus_noise(1'b0, 1'b1));
    send_cycle(bus_read(OFF_NMI_LO | TMR_ONESHOT_BIT));
    // Largest count, one-shot, then stopped by a low-byte write
    send_cycle(bus_write(OFF_NMI_LO, 8'hFF));
    send_cycle(bus_write(OFF_NMI_LO | TMR_HI_BIT | TMR_ONESHOT_BIT, 8'hFF));
    send_cycle(bus_write(OFF_NMI_LO, 8'h00));
    // Watchdog: full bytes, status, stop, short run with a restart, trap
    send_cycle(bus_write(OFF_WD_B0, 8'hFF));
    send_cycle(bus_write(OFF_WD_B1, 8'hFF));
    send_cycle(bus_read(OFF_WD_STOP));
    send_cycle(bus_write(OFF_WD_STOP, 8'hFF));
    send_cycle(bus_write(OFF_WD_B0, 8'h02));
    send_cycle(bus_write(OFF_WD_B2, 8'h00));
    send_cycle(bus_write(OFF_WD_B0, 8'h55));
    send_cycle(bus_noise(1'b0, 1'b1));
    send_cycle(bus_noise(1'b0, 1'b1));
    send_cycle(bus_read(OFF_WD_B2));
    // Reset held with a random access, deselected random access, unmapped read
    send_cycle(bus_noise(1'b1, 1'b0));
    send_cycle(bus_noise(1'b0, 1'b1));
    send_cycle(bus_read(OFF_UNMAPPED));

    tx_gaps = 1;
    rx_stalls = 1;
    run_random(500);
    // Receiver holds off while the sender keeps offering
    long_hold_req = 1;
    run_random(items_sent + 150);
    wait_drained();
    run_random(1300);
    tx_gaps = 0;
    rx_stalls = 0;
    run_random(1520);
    s_tvalid = 1'b0;

    for (int n = 0; n < 2000 && sb.expected_q.size() != 0; n++) @(negedge clk);
    repeat (5) @(negedge clk);

    if (sb.expected_q.size() != 0)
      $display("%0d expected results never arrived", sb.expected_q.size());
    $display("Covered %0d bus cycles, %0d results checked, %0d status reads,",
             items_sent, sb.checked, sb.status_reads);
    $display("%0d timer expiries and %0d watchdog traps; %0d mismatches",
             sb.timer_fires, sb.traps_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog on the run itself
  initial begin
    #3000000;
    $display("Timeout with %0d results pending", sb.expected_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
